@@ rtl/fsu_pkg.sv @@
// Shared types and constants of the Forth data-stack unit.
// Used by fsu_cell_ram, fsu_walker and forth_stack_unit_top; depends on nothing.
package fsu_pkg;

   // Default stack capacity in cells.
   localparam int unsigned STACK_CELLS_DEF = 256;

   // Fixed field widths.
   localparam int CELL_W   = 32;
   localparam int KIND_W   = 3;
   localparam int STATUS_W = 2;

   // Minimum depths that OVER and ROT need before they run.
   localparam int OVER_MIN = 2;
   localparam int ROT_MIN  = 3;

   // Command codes; the two remaining codes are unimplemented words.
   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH  = 3'd0,
      KIND_DEPTH = 3'd1,
      KIND_ROLL  = 3'd2,
      KIND_OVER  = 3'd3,
      KIND_PICK  = 3'd4,
      KIND_ROT   = 3'd5
   } kind_type;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NEG_PICK = 2'd1,
      STATUS_UNIMPL   = 2'd2,
      STATUS_OVERFLOW = 2'd3
   } status_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_PUSH,
      S_LIFT,
      S_OVER_RD,
      S_OVER_WR,
      S_ROT_RDA,
      S_ROT_RDB,
      S_ROT_WRB,
      S_ROT_WRC,
      S_PICK_WR,
      S_ROLL_RD,
      S_ROLL_SAVE,
      S_ROLL_WALK,
      S_ROLL_PUT,
      S_TOP_RD,
      S_TOP_CAP
   } state_type;

   // Command from the sequencer to the block-move walker.
   typedef struct packed {
      logic start;
      logic ascend;
   } walk_ctl_type;

   // Memory port enables driven by the walker.
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } ram_en_type;

endpackage

@@ rtl/fsu_cell_ram.sv @@
// Cell store of the data stack: one write port and one registered read port.
// Depends on fsu_pkg for the cell width.
module fsu_cell_ram #(
   parameter int DEPTH = fsu_pkg::STACK_CELLS_DEF,
   parameter int AW    = $clog2(fsu_pkg::STACK_CELLS_DEF)
) (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [AW-1:0]              rd_addr,
   output logic [fsu_pkg::CELL_W-1:0] rd_data,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [fsu_pkg::CELL_W-1:0] wr_data
);

   logic [fsu_pkg::CELL_W-1:0] mem_ff [DEPTH];
   logic [fsu_pkg::CELL_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/fsu_walker.sv @@
// Block-move walker: copies a run of cells one address a cycle, reading the
// source at a fixed gap above or below the destination, zero below entry 0.
// Depends on fsu_pkg for the control structs and the cell width.
module fsu_walker #(
   parameter int AW = $clog2(fsu_pkg::STACK_CELLS_DEF),
   parameter int DW = $clog2(fsu_pkg::STACK_CELLS_DEF + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  fsu_pkg::walk_ctl_type      ctl,
   input  logic [AW-1:0]              first_addr,
   input  logic [DW-1:0]              cells,
   input  logic [DW-1:0]              gap,
   output logic                       busy,
   output fsu_pkg::ram_en_type        ram_en,
   output logic [AW-1:0]              rd_addr,
   output logic [AW-1:0]              wr_addr,
   input  logic [fsu_pkg::CELL_W-1:0] rd_data,
   output logic [fsu_pkg::CELL_W-1:0] wr_data
);

   logic [AW-1:0] dst_ff,      dst_in;
   logic [DW-1:0] left_ff,     left_in;
   logic          asc_ff,      asc_in;
   logic [DW-1:0] gap_ff,      gap_in;
   logic          wr_pend_ff,  wr_pend_in;
   logic [AW-1:0] wr_addr_ff,  wr_addr_in;
   logic          wr_zero_ff,  wr_zero_in;

   logic          issuing;
   logic          src_ok;
   logic [DW-1:0] src_up;
   logic [DW-1:0] src_down;

   // Source address: the gap above the destination, or below it.
   assign issuing  = (left_ff != '0);
   assign src_up   = DW'(dst_ff) + gap_ff;
   assign src_down = DW'(dst_ff) - gap_ff;
   assign src_ok   = asc_ff || (DW'(dst_ff) >= gap_ff);

   // Read one source a cycle; write it back in the cycle after.
   always_comb begin
      dst_in     = dst_ff;
      left_in    = left_ff;
      asc_in     = asc_ff;
      gap_in     = gap_ff;
      wr_pend_in = issuing;
      wr_addr_in = dst_ff;
      wr_zero_in = !src_ok;
      if (ctl.start) begin
         dst_in  = first_addr;
         left_in = cells;
         asc_in  = ctl.ascend;
         gap_in  = gap;
      end else if (issuing) begin
         dst_in  = asc_ff ? (dst_ff + AW'(1)) : (dst_ff - AW'(1));
         left_in = left_ff - DW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff    <= '0;
         wr_pend_ff <= 1'b0;
      end else begin
         left_ff    <= left_in;
         wr_pend_ff <= wr_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      dst_ff     <= dst_in;
      asc_ff     <= asc_in;
      gap_ff     <= gap_in;
      wr_addr_ff <= wr_addr_in;
      wr_zero_ff <= wr_zero_in;
   end

   // Memory port.
   assign ram_en.rd_en = issuing && src_ok;
   assign ram_en.wr_en = wr_pend_ff;
   assign rd_addr      = asc_ff ? AW'(src_up) : AW'(src_down);
   assign wr_addr      = wr_addr_ff;
   assign wr_data      = wr_zero_ff ? '0 : rd_data;
   assign busy         = issuing || wr_pend_ff;

endmodule

@@ rtl/forth_stack_unit_top.sv @@
// Top level of the Forth data-stack unit: command sequencer, stack registers
// and result register. Uses fsu_cell_ram, fsu_walker and fsu_pkg.
//
//  channel  | ports                                          | direction
//  ---------+------------------------------------------------+----------
//  command  | start, busy, req_kind, req_push_value          | in, busy out
//  result   | rsp_valid, rsp_status, rsp_top_cell,           | out
//           | rsp_stack_depth                                |
//
// A command beat is taken when start is high and busy is low; its result
// beat follows on rsp_valid for exactly one cycle. OVER, ROT and ROLL on
// a stack too short for them first lift zero cells in under it with the
// walker, which moves one cell a cycle over the single memory port, and
// then run the word proper. Reset empties the stack at once. The receiver
// cannot stall; busy is low again when rsp_valid rises.
module forth_stack_unit_top #(
   parameter int STACK_CELLS = fsu_pkg::STACK_CELLS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [fsu_pkg::KIND_W-1:0]             req_kind,
   input  logic signed [fsu_pkg::CELL_W-1:0]      req_push_value,
   output logic                                   rsp_valid,
   output logic [fsu_pkg::STATUS_W-1:0]           rsp_status,
   output logic signed [fsu_pkg::CELL_W-1:0]      rsp_top_cell,
   output logic [$clog2(STACK_CELLS + 1)-1:0]     rsp_stack_depth
);

   localparam int AW = $clog2(STACK_CELLS);
   localparam int DW = $clog2(STACK_CELLS + 1);
   localparam int CW = fsu_pkg::CELL_W;
   localparam logic [CW-1:0] CAP_CELL = CW'(STACK_CELLS);
   localparam logic [DW-1:0] CAP      = DW'(STACK_CELLS);

   // Sequencer and stack registers.
   fsu_pkg::state_type  state_ff, state_in;
   logic [DW-1:0]       depth_ff, depth_in;
   logic [CW-1:0]       top_ff,   top_in;
   logic [CW-1:0]       hold_ff,  hold_in;
   fsu_pkg::kind_type   op_ff,    op_in;
   logic [AW-1:0]       count_ff, count_in;
   logic                neg_ff,   neg_in;
   logic                hit_ff,   hit_in;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   fsu_pkg::status_type rsp_status_ff;
   logic [CW-1:0]       rsp_top_ff;
   logic [DW-1:0]       rsp_depth_ff;

   logic                fin;
   fsu_pkg::status_type fin_status;

   // Lift request: zero cells slide in under the stack up to lift_need.
   logic                lift_go;
   logic [DW-1:0]       lift_need;
   logic [DW-1:0]       lift_base;

   // Derived stack quantities.
   logic [DW-1:0]       dp;
   logic                full;
   logic [CW-1:0]       roll_mag;
   logic                roll_ovf;
   logic [DW-1:0]       roll_need;
   logic [AW-1:0]       roll_base;
   logic [CW-1:0]       pick_v;

   // Sequencer memory requests.
   logic                seq_rd_en;
   logic [AW-1:0]       seq_rd_addr;
   logic                seq_wr_en;
   logic [AW-1:0]       seq_wr_addr;
   logic [CW-1:0]       seq_wr_data;

   // Walker interface.
   fsu_pkg::walk_ctl_type wk_ctl;
   logic [AW-1:0]         wk_first;
   logic [DW-1:0]         wk_cells;
   logic [DW-1:0]         wk_gap;
   logic                  wk_busy;
   fsu_pkg::ram_en_type   wk_en;
   logic [AW-1:0]         wk_rd_addr;
   logic [AW-1:0]         wk_wr_addr;
   logic [CW-1:0]         wk_wr_data;

   // Memory port.
   logic                ram_rd_en;
   logic [AW-1:0]       ram_rd_addr;
   logic [CW-1:0]       ram_rd_data;
   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   logic [CW-1:0]       ram_wr_data;

   // Depth after one pop, capacity check and the ROLL count.
   assign dp        = (depth_ff == '0) ? '0 : (depth_ff - DW'(1));
   assign full      = (depth_ff == CAP);
   assign roll_mag  = top_ff[CW-1] ? (~top_ff + CW'(1)) : top_ff;
   assign roll_ovf  = (roll_mag >= CAP_CELL);
   assign roll_need = DW'(roll_mag) + DW'(1);
   assign roll_base = AW'(depth_ff - DW'(1) - DW'(count_ff));
   assign pick_v    = hit_ff ? ram_rd_data : '0;

   // Next state, memory requests and walker commands.
   always_comb begin
      state_in    = state_ff;
      depth_in    = depth_ff;
      top_in      = top_ff;
      hold_in     = hold_ff;
      op_in       = op_ff;
      count_in    = count_ff;
      neg_in      = neg_ff;
      hit_in      = hit_ff;
      seq_rd_en   = 1'b0;
      seq_rd_addr = '0;
      seq_wr_en   = 1'b0;
      seq_wr_addr = '0;
      seq_wr_data = '0;
      wk_ctl      = '0;
      wk_first    = '0;
      wk_cells    = '0;
      wk_gap      = '0;
      lift_go     = 1'b0;
      lift_need   = '0;
      lift_base   = '0;
      fin         = 1'b0;
      fin_status  = fsu_pkg::STATUS_OK;

      case (state_ff)
         fsu_pkg::S_IDLE: begin
            if (start) begin
               op_in = fsu_pkg::kind_type'(req_kind);
               case (req_kind)
                  fsu_pkg::KIND_PUSH, fsu_pkg::KIND_DEPTH: begin
                     if (full) begin
                        fin        = 1'b1;
                        fin_status = fsu_pkg::STATUS_OVERFLOW;
                     end else begin
                        hold_in  = (req_kind == fsu_pkg::KIND_DEPTH) ?
                                   CW'(depth_ff) : $unsigned(req_push_value);
                        state_in = fsu_pkg::S_PUSH;
                     end
                  end
                  fsu_pkg::KIND_OVER: begin
                     if (full) begin
                        fin        = 1'b1;
                        fin_status = fsu_pkg::STATUS_OVERFLOW;
                     end else if (depth_ff < DW'(fsu_pkg::OVER_MIN)) begin
                        lift_go   = 1'b1;
                        lift_need = DW'(fsu_pkg::OVER_MIN);
                        lift_base = depth_ff;
                     end else begin
                        seq_rd_en   = 1'b1;
                        seq_rd_addr = AW'(depth_ff - DW'(2));
                        state_in    = fsu_pkg::S_OVER_WR;
                     end
                  end
                  fsu_pkg::KIND_ROT: begin
                     if (depth_ff < DW'(fsu_pkg::ROT_MIN)) begin
                        lift_go   = 1'b1;
                        lift_need = DW'(fsu_pkg::ROT_MIN);
                        lift_base = depth_ff;
                     end else begin
                        seq_rd_en   = 1'b1;
                        seq_rd_addr = AW'(depth_ff - DW'(3));
                        state_in    = fsu_pkg::S_ROT_RDB;
                     end
                  end
                  fsu_pkg::KIND_PICK: begin
                     // The index is popped; a negative one ends the word.
                     neg_in   = top_ff[CW-1];
                     depth_in = dp;
                     if (top_ff[CW-1]) begin
                        hit_in      = (depth_ff >= DW'(2));
                        seq_rd_en   = (depth_ff >= DW'(2));
                        seq_rd_addr = AW'(depth_ff - DW'(2));
                     end else begin
                        hit_in      = (CW'(dp) > top_ff);
                        seq_rd_en   = (CW'(dp) > top_ff);
                        seq_rd_addr = AW'(CW'(dp) - CW'(1) - top_ff);
                     end
                     state_in = fsu_pkg::S_PICK_WR;
                  end
                  fsu_pkg::KIND_ROLL: begin
                     if (roll_ovf) begin
                        fin        = 1'b1;
                        fin_status = fsu_pkg::STATUS_OVERFLOW;
                     end else begin
                        neg_in   = top_ff[CW-1];
                        count_in = AW'(roll_mag);
                        depth_in = dp;
                        if (dp < roll_need) begin
                           lift_go   = 1'b1;
                           lift_need = roll_need;
                           lift_base = dp;
                        end else if (roll_mag == '0) begin
                           state_in = fsu_pkg::S_TOP_RD;
                        end else begin
                           state_in = fsu_pkg::S_ROLL_RD;
                        end
                     end
                  end
                  default: begin
                     fin        = 1'b1;
                     fin_status = fsu_pkg::STATUS_UNIMPL;
                  end
               endcase
            end
         end

         fsu_pkg::S_PUSH: begin
            seq_wr_en   = 1'b1;
            seq_wr_addr = AW'(depth_ff);
            seq_wr_data = hold_ff;
            depth_in    = depth_ff + DW'(1);
            top_in      = hold_ff;
            fin         = 1'b1;
         end

         // Wait for the lift to finish, then run the word proper.
         fsu_pkg::S_LIFT: begin
            if (!wk_busy) begin
               case (op_ff)
                  fsu_pkg::KIND_OVER: state_in = fsu_pkg::S_OVER_RD;
                  fsu_pkg::KIND_ROT:  state_in = fsu_pkg::S_ROT_RDA;
                  fsu_pkg::KIND_ROLL: begin
                     state_in = (count_ff == '0) ? fsu_pkg::S_TOP_RD :
                                                   fsu_pkg::S_ROLL_RD;
                  end
                  default:            state_in = fsu_pkg::S_IDLE;
               endcase
            end
         end

         fsu_pkg::S_OVER_RD: begin
            seq_rd_en   = 1'b1;
            seq_rd_addr = AW'(depth_ff - DW'(2));
            state_in    = fsu_pkg::S_OVER_WR;
         end

         fsu_pkg::S_OVER_WR: begin
            seq_wr_en   = 1'b1;
            seq_wr_addr = AW'(depth_ff);
            seq_wr_data = ram_rd_data;
            depth_in    = depth_ff + DW'(1);
            top_in      = ram_rd_data;
            fin         = 1'b1;
         end

         fsu_pkg::S_ROT_RDA: begin
            seq_rd_en   = 1'b1;
            seq_rd_addr = AW'(depth_ff - DW'(3));
            state_in    = fsu_pkg::S_ROT_RDB;
         end

         // The third cell goes to the top while the second is read.
         fsu_pkg::S_ROT_RDB: begin
            seq_rd_en   = 1'b1;
            seq_rd_addr = AW'(depth_ff - DW'(2));
            seq_wr_en   = 1'b1;
            seq_wr_addr = AW'(depth_ff - DW'(1));
            seq_wr_data = ram_rd_data;
            hold_in     = top_ff;
            top_in      = ram_rd_data;
            state_in    = fsu_pkg::S_ROT_WRB;
         end

         fsu_pkg::S_ROT_WRB: begin
            seq_wr_en   = 1'b1;
            seq_wr_addr = AW'(depth_ff - DW'(3));
            seq_wr_data = ram_rd_data;
            state_in    = fsu_pkg::S_ROT_WRC;
         end

         fsu_pkg::S_ROT_WRC: begin
            seq_wr_en   = 1'b1;
            seq_wr_addr = AW'(depth_ff - DW'(2));
            seq_wr_data = hold_ff;
            fin         = 1'b1;
         end

         fsu_pkg::S_PICK_WR: begin
            top_in = pick_v;
            fin    = 1'b1;
            if (neg_ff) begin
               fin_status = fsu_pkg::STATUS_NEG_PICK;
            end else begin
               seq_wr_en   = 1'b1;
               seq_wr_addr = AW'(depth_ff);
               seq_wr_data = pick_v;
               depth_in    = depth_ff + DW'(1);
            end
         end

         // Save the cell that jumps over the window.
         fsu_pkg::S_ROLL_RD: begin
            seq_rd_en   = 1'b1;
            seq_rd_addr = neg_ff ? AW'(depth_ff - DW'(1)) : roll_base;
            state_in    = fsu_pkg::S_ROLL_SAVE;
         end

         fsu_pkg::S_ROLL_SAVE: begin
            hold_in       = ram_rd_data;
            wk_ctl.start  = 1'b1;
            wk_ctl.ascend = !neg_ff;
            wk_first      = neg_ff ? AW'(depth_ff - DW'(1)) : roll_base;
            wk_cells      = DW'(count_ff);
            wk_gap        = DW'(1);
            state_in      = fsu_pkg::S_ROLL_WALK;
         end

         fsu_pkg::S_ROLL_WALK: begin
            if (!wk_busy) begin
               state_in = fsu_pkg::S_ROLL_PUT;
            end
         end

         fsu_pkg::S_ROLL_PUT: begin
            seq_wr_en   = 1'b1;
            seq_wr_addr = neg_ff ? roll_base : AW'(depth_ff - DW'(1));
            seq_wr_data = hold_ff;
            if (neg_ff) begin
               state_in = fsu_pkg::S_TOP_RD;
            end else begin
               top_in = hold_ff;
               fin    = 1'b1;
            end
         end

         // Refresh the cached top cell from the store.
         fsu_pkg::S_TOP_RD: begin
            seq_rd_en   = 1'b1;
            seq_rd_addr = AW'(depth_ff - DW'(1));
            state_in    = fsu_pkg::S_TOP_CAP;
         end

         fsu_pkg::S_TOP_CAP: begin
            top_in = ram_rd_data;
            fin    = 1'b1;
         end

         default: begin
            state_in = fsu_pkg::S_IDLE;
         end
      endcase

      // Lift the stack: cells move up, zeros fill in from entry 0.
      if (lift_go) begin
         wk_ctl.start  = 1'b1;
         wk_ctl.ascend = 1'b0;
         wk_first      = AW'(lift_need - DW'(1));
         wk_cells      = lift_need;
         wk_gap        = lift_need - lift_base;
         depth_in      = lift_need;
         state_in      = fsu_pkg::S_LIFT;
      end

      if (fin) begin
         state_in = fsu_pkg::S_IDLE;
      end
      rsp_valid_in = fin;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fsu_pkg::S_IDLE;
         depth_ff     <= '0;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers of the current word.
   always_ff @(posedge clock) begin
      hold_ff  <= hold_in;
      op_ff    <= op_in;
      count_ff <= count_in;
      neg_ff   <= neg_in;
      hit_ff   <= hit_in;
   end

   // Result beat payload, loaded as the word finishes.
   always_ff @(posedge clock) begin
      if (fin) begin
         rsp_status_ff <= fin_status;
         rsp_top_ff    <= top_in;
         rsp_depth_ff  <= depth_in;
      end
   end

   // Memory port goes to the walker while it runs.
   assign ram_rd_en   = wk_busy ? wk_en.rd_en : seq_rd_en;
   assign ram_rd_addr = wk_busy ? wk_rd_addr  : seq_rd_addr;
   assign ram_wr_en   = wk_busy ? wk_en.wr_en : seq_wr_en;
   assign ram_wr_addr = wk_busy ? wk_wr_addr  : seq_wr_addr;
   assign ram_wr_data = wk_busy ? wk_wr_data  : seq_wr_data;

   fsu_cell_ram #(
      .DEPTH (STACK_CELLS),
      .AW    (AW)
   ) u_cell_ram (
      .clock   (clock),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data)
   );

   fsu_walker #(
      .AW (AW),
      .DW (DW)
   ) u_walker (
      .clock      (clock),
      .reset      (reset),
      .ctl        (wk_ctl),
      .first_addr (wk_first),
      .cells      (wk_cells),
      .gap        (wk_gap),
      .busy       (wk_busy),
      .ram_en     (wk_en),
      .rd_addr    (wk_rd_addr),
      .wr_addr    (wk_wr_addr),
      .rd_data    (ram_rd_data),
      .wr_data    (wk_wr_data)
   );

   // Ports.
   assign busy            = (state_ff != fsu_pkg::S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_top_cell    = rsp_top_ff;
   assign rsp_stack_depth = rsp_depth_ff;

endmodule
